// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the queue rtl
// included by files that carry concurrent checks; empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define LQR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent holds in the cycle after the antecedent
`define LQR_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define LQR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LQR_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg)
`endif

`endif

// ----- rtl/core/lqr_pkg.sv -----
// shared types and codes for the linear queue with reverse
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lqr_pkg;

    localparam int LQR_DEPTH = 8;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 4;

    // request codes
    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_DEQ = 2'd1;
    localparam logic [1:0] REQ_REV = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data_out;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/lqr_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/lqr_seq.sv -----
// sequencer for the queue: pointers, request decode and the reverse walk
// depends on lqr_pkg and assert_macros.svh; drives two lqr_ram instances
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lqr_seq #(
    parameter int DEPTH = 8,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire lqr_pkg::req_t             req,
    output logic                           idle,
    output logic                           done,
    input  wire logic                      done_ready,
    output lqr_pkg::rsp_t                  rsp,
    output logic                           q_we,
    output logic [IW-1:0]                  q_waddr,
    output logic [lqr_pkg::DATA_W-1:0]     q_wdata,
    output logic [IW-1:0]                  q_raddr,
    input  wire logic [lqr_pkg::DATA_W-1:0] q_rdata,
    output logic                           r_we,
    output logic [IW-1:0]                  r_waddr,
    output logic [lqr_pkg::DATA_W-1:0]     r_wdata,
    output logic [IW-1:0]                  r_raddr,
    input  wire logic [lqr_pkg::DATA_W-1:0] r_rdata
);

    import lqr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DEQ   = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_PUSHW = 3'd4;
    localparam logic [2:0] S_POP   = 3'd5;
    localparam logic [2:0] S_POPW  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic              empty_reg, empty_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     sc_reg, sc_next;
    logic [1:0]        st_reg, st_next;
    logic [DATA_W-1:0] dout_reg, dout_next;
    req_t              req_reg;

    logic [CW-1:0] add_base, add_off, add_sum;
    logic [CW-1:0] held;
    logic [CW-1:0] i_inc;
    logic          full;

    assign held  = empty_reg ? '0 : (CW'(tail_reg) - CW'(head_reg) + CW'(1));
    assign full  = !empty_reg && (tail_reg == IW'(DEPTH - 1));
    assign i_inc = i_reg + CW'(1);

    // shared address adder
    always_comb
    begin
        case (state_reg)
            S_EXEC:
            begin
                add_base = CW'(tail_reg);
                add_off  = CW'(1);
            end
            S_PUSH:
            begin
                add_base = CW'(head_reg);
                add_off  = i_reg;
            end
            S_POP:
            begin
                add_base = sc_reg;
                add_off  = '1;
            end
            default:
            begin
                add_base = CW'(head_reg);
                add_off  = CW'(1);
            end
        endcase
    end
    assign add_sum = add_base + add_off;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        sc_next    = sc_reg;
        st_next    = st_reg;
        dout_next  = dout_reg;
        q_we       = 1'b0;
        q_waddr    = add_sum[IW-1:0];
        q_wdata    = req_reg.data_in;
        q_raddr    = head_reg;
        r_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next    = ST_OK;
                dout_next  = '0;
                state_next = S_DONE;
                case (req_reg.req_type)
                    REQ_ENQ:
                    begin
                        if (empty_reg)
                        begin
                            q_we       = 1'b1;
                            q_waddr    = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b0;
                        end
                        else if (full)
                        begin
                            st_next = ST_OVF;
                        end
                        else
                        begin
                            q_we      = 1'b1;
                            tail_next = add_sum[IW-1:0];
                        end
                    end
                    REQ_DEQ:
                    begin
                        if (empty_reg)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_DEQ;
                        end
                    end
                    REQ_REV:
                    begin
                        if (!empty_reg)
                        begin
                            n_next     = held;
                            i_next     = '0;
                            sc_next    = '0;
                            state_next = S_PUSH;
                        end
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_DEQ:
            begin
                dout_next = q_rdata;
                if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = add_sum[IW-1:0];
                end
                state_next = S_DONE;
            end
            S_PUSH:
            begin
                q_raddr    = add_sum[IW-1:0];
                state_next = S_PUSHW;
            end
            S_PUSHW:
            begin
                r_we    = 1'b1;
                sc_next = sc_reg + CW'(1);
                if (i_inc == n_reg)
                begin
                    i_next     = '0;
                    state_next = S_POP;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_PUSH;
                end
            end
            S_POP:
            begin
                sc_next    = add_sum;
                state_next = S_POPW;
            end
            S_POPW:
            begin
                q_we    = 1'b1;
                q_waddr = i_reg[IW-1:0];
                q_wdata = r_rdata;
                if (i_inc == n_reg)
                begin
                    i_next     = '0;
                    head_next  = '0;
                    tail_next  = IW'(n_reg - CW'(1));
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_POP;
                end
            end
            S_DONE:
            begin
                if (done_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // scratch stack ports: push writes at the stack pointer, pop reads one below it
    assign r_waddr = sc_reg[IW-1:0];
    assign r_wdata = q_rdata;
    assign r_raddr = add_sum[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            n_reg     <= '0;
            i_reg     <= '0;
            sc_reg    <= '0;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            sc_reg    <= sc_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
        if (start)
        begin
            req_reg <= req;
        end
    end

    assign idle          = (state_reg == S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign rsp.status    = st_reg;
    assign rsp.data_out  = dout_reg;
    assign rsp.occupancy = OCC_W'(held);

    `LQR_ASSERT(a_empty_ptrs, clk, rst_n, empty_reg |-> (head_reg == '0 && tail_reg == '0), "empty queue with nonzero pointers")
    `LQR_ASSERT(a_ptr_order, clk, rst_n, !empty_reg |-> (tail_reg >= head_reg), "tail behind head")
    `LQR_ASSERT(a_stack_idle, clk, rst_n, (state_reg == S_IDLE) |-> (sc_reg == '0), "scratch stack not drained")
    `LQR_ASSERT_NEXT(a_done_ret, clk, rst_n, (state_reg == S_DONE && done_ready), (state_reg == S_IDLE), "result taken but sequencer not idle")

endmodule

`default_nettype wire

// ----- rtl/core/linear_queue_with_reverse_core.sv -----
// top level of the linear queue with reverse: sequencer, two rams, result register
// depends on lqr_pkg, lqr_ram and lqr_seq
`timescale 1ns / 1ps
`default_nettype none

// Linear (non-wrapping) queue of DEPTH signed 32-bit words taking enqueue,
// dequeue and reverse requests, one result transaction per request. The
// queue accepts one request at a time. A dequeue that returns a word adds a
// registered queue ram read before its result. A reverse of n held words
// moves every word through the scratch ram with one registered read and one
// write each way, pushing all n words and then popping them back. The
// sequencer waits in its done state while the output register is full. A
// finished result sits in the output register while the next request is
// taken. Enqueue reports overflow whenever the tail is at the last slot;
// slots are reused only after the queue drains or a reverse packs it to slot 0.
module linear_queue_with_reverse_core #(
    parameter int DEPTH = lqr_pkg::LQR_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire lqr_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output lqr_pkg::rsp_t      rsp
);

    import lqr_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              seq_idle;
    logic              seq_done;
    logic              done_ready;
    rsp_t              seq_rsp;
    logic              q_we, r_we;
    logic [IW-1:0]     q_waddr, q_raddr, r_waddr, r_raddr;
    logic [DATA_W-1:0] q_wdata, q_rdata, r_wdata, r_rdata;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    assign req_ready  = seq_idle;
    assign done_ready = !rsp_valid_reg || rsp_ready;

    lqr_seq #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (req_valid && req_ready),
        .req        (req),
        .idle       (seq_idle),
        .done       (seq_done),
        .done_ready (done_ready),
        .rsp        (seq_rsp),
        .q_we       (q_we),
        .q_waddr    (q_waddr),
        .q_wdata    (q_wdata),
        .q_raddr    (q_raddr),
        .q_rdata    (q_rdata),
        .r_we       (r_we),
        .r_waddr    (r_waddr),
        .r_wdata    (r_wdata),
        .r_raddr    (r_raddr),
        .r_rdata    (r_rdata)
    );

    lqr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    lqr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // output register: holds one result transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (seq_done && done_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done && done_ready)
        begin
            rsp_reg <= seq_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
